// ===== rtl/velocity_pid_deadband_top_macros.svh =====
// ----------------------------------------------------------------------------
// velocity_pid_deadband_top_macros
// assertion macros used by the checker file vpd_checker
// ----------------------------------------------------------------------------
`ifndef VELOCITY_PID_DEADBAND_TOP_MACROS_SVH
`define VELOCITY_PID_DEADBAND_TOP_MACROS_SVH

// clocked assertion, off while reset is held
`define VPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// clocked assertion that also checks during reset
`define VPD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/vpd_pkg.sv =====
// ----------------------------------------------------------------------------
// vpd_pkg
// types, widths and codes of the velocity-form pid controller
// ----------------------------------------------------------------------------
package vpd_pkg;

  localparam int FRAC_BITS = 16;
  localparam int VAL_W     = 16;
  localparam int DB_W      = 15;
  localparam int COEF_W    = 24;
  localparam int MODE_W    = 2;
  localparam int ERR_W     = VAL_W + 1;
  localparam int ACC_W     = VAL_W + FRAC_BITS;
  localparam int PROD_W    = COEF_W + ERR_W;
  localparam int SUM_W     = ((PROD_W > ACC_W) ? PROD_W : ACC_W) + 2;

  localparam int MODE_AUTO_BIT = 0;
  localparam int MODE_INV_BIT  = 1;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_MANUAL = 2'd1,
    OP_CLEAR  = 2'd2
  } opcode_t;

  typedef enum logic [2:0] {
    REG_SETPOINT  = 3'd0,
    REG_DEADBAND  = 3'd1,
    REG_UPPER     = 3'd2,
    REG_LOWER     = 3'd3,
    REG_COEF_CUR  = 3'd4,
    REG_COEF_PREV = 3'd5,
    REG_COEF_OLD  = 3'd6,
    REG_MODE      = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic signed [VAL_W-1:0]  setpoint;
    logic        [DB_W-1:0]   deadband;
    logic signed [VAL_W-1:0]  upper_limit;
    logic signed [VAL_W-1:0]  lower_limit;
    logic signed [COEF_W-1:0] coef_current;
    logic signed [COEF_W-1:0] coef_previous;
    logic signed [COEF_W-1:0] coef_older;
    logic        [MODE_W-1:0] mode_bits;
  } cfg_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] accum;
    logic signed [ERR_W-1:0] err_now;
    logic signed [ERR_W-1:0] err_prev;
    logic signed [ERR_W-1:0] err_older;
  } pid_state_t;

endpackage

// ===== rtl/vpd_datapath.sv =====
// ----------------------------------------------------------------------------
// vpd_datapath
// one-pass update of the pid state for a single item
// ----------------------------------------------------------------------------
module vpd_datapath (
  input  vpd_pkg::cfg_t                   cfg,
  input  vpd_pkg::pid_state_t             state,
  input  logic [1:0]                      opcode,
  input  logic signed [vpd_pkg::VAL_W-1:0] sample_value,
  output vpd_pkg::pid_state_t             state_nxt,
  output logic                            updated
);
  import vpd_pkg::*;

  logic                     is_auto;
  logic                     inverse;
  logic signed [ERR_W-1:0]  err;
  logic        [ERR_W-1:0]  mag;
  logic                     outside_db;
  logic signed [PROD_W-1:0] prod_cur;
  logic signed [PROD_W-1:0] prod_prev;
  logic signed [PROD_W-1:0] prod_old;
  logic signed [SUM_W-1:0]  pid_sum;
  logic signed [SUM_W-1:0]  manual_val;
  logic signed [SUM_W-1:0]  lim_lo;
  logic signed [SUM_W-1:0]  lim_hi;
  logic signed [SUM_W-1:0]  cand;
  logic signed [SUM_W-1:0]  clamped;
  logic                     do_pid;
  logic                     do_manual;

  assign is_auto = cfg.mode_bits[MODE_AUTO_BIT];
  assign inverse = cfg.mode_bits[MODE_INV_BIT];

  always_comb begin
    if (inverse) begin
      err = ERR_W'(sample_value) - ERR_W'(cfg.setpoint);
    end else begin
      err = ERR_W'(cfg.setpoint) - ERR_W'(sample_value);
    end
    mag = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
  end

  assign outside_db = (mag >= {{(ERR_W-DB_W){1'b0}}, cfg.deadband});
  assign do_pid     = (opcode_t'(opcode) == OP_SAMPLE) && is_auto && outside_db;
  assign do_manual  = (opcode_t'(opcode) == OP_MANUAL) && !is_auto;

  // newest error goes to the current gain, history moves one slot
  assign prod_cur  = cfg.coef_current  * err;
  assign prod_prev = cfg.coef_previous * state.err_now;
  assign prod_old  = cfg.coef_older    * state.err_prev;

  assign pid_sum = SUM_W'(state.accum) + SUM_W'(prod_cur) + SUM_W'(prod_prev)
                 + SUM_W'(prod_old);

  assign manual_val = SUM_W'(sample_value) <<< FRAC_BITS;
  assign lim_lo     = SUM_W'(cfg.lower_limit) <<< FRAC_BITS;
  assign lim_hi     = SUM_W'(cfg.upper_limit) <<< FRAC_BITS;

  assign cand = do_pid ? pid_sum : manual_val;

  // lower bound is tested first; with crossed limits a value below lower goes to lower, anything else to upper
  always_comb begin
    if (cand < lim_lo) begin
      clamped = lim_lo;
    end else if (cand > lim_hi) begin
      clamped = lim_hi;
    end else begin
      clamped = cand;
    end
  end

  always_comb begin
    state_nxt = state;
    updated   = 1'b0;
    case (opcode_t'(opcode))
      OP_SAMPLE: begin
        if (do_pid) begin
          state_nxt.accum     = clamped[ACC_W-1:0];
          state_nxt.err_now   = err;
          state_nxt.err_prev  = state.err_now;
          state_nxt.err_older = state.err_prev;
          updated             = 1'b1;
        end
      end
      OP_MANUAL: begin
        if (do_manual) begin
          state_nxt.accum = clamped[ACC_W-1:0];
        end
      end
      OP_CLEAR: begin
        state_nxt = '0;
      end
      default: begin
        state_nxt = state;
      end
    endcase
  end

endmodule

// ===== rtl/velocity_pid_deadband_top.sv =====
// an accepted input beat passes the input register and then the result register to become its result beat
// throughput: one item per cycle while the result side does not stall; the accumulator update and clamp
//   are combinational between the input register and the result register
// reset (rst_n low, synchronous): output accumulator and error history cleared,
//   registers back to their reset values, both pipeline slots emptied
// ----------------------------------------------------------------------------
// velocity_pid_deadband_top
// incremental pid controller with deadband and output clamp, apb configured
// ----------------------------------------------------------------------------
module velocity_pid_deadband_top (
  input  logic        clk,
  input  logic        rst_n,
  // apb configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] sample_value
  input  logic [1:0]  in_tuser,   // [1:0] opcode
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] drive_output
  output logic        out_tuser   // [0] pid_updated
);
  import vpd_pkg::*;

  cfg_t                    cfg_r;
  pid_state_t              state_r;
  pid_state_t              state_nxt;
  logic                    updated;

  logic                    s1_valid_r;
  logic [1:0]              s1_op_r;
  logic signed [VAL_W-1:0] s1_val_r;
  logic                    s1_move;

  logic                    out_valid_r;
  logic [15:0]             out_data_r;
  logic                    out_upd_r;
  logic                    cfg_wr;

  // ---------------- configuration ----------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.setpoint      <= '0;
      cfg_r.deadband      <= '0;
      cfg_r.upper_limit   <= 16'sh7fff;
      cfg_r.lower_limit   <= 16'sh8000;
      cfg_r.coef_current  <= '0;
      cfg_r.coef_previous <= '0;
      cfg_r.coef_older    <= '0;
      cfg_r.mode_bits     <= '0;
    end else if (cfg_wr) begin
      case (reg_idx_t'(cfg_paddr[4:2]))
        REG_SETPOINT:  cfg_r.setpoint      <= cfg_pwdata[VAL_W-1:0];
        REG_DEADBAND:  cfg_r.deadband      <= cfg_pwdata[DB_W-1:0];
        REG_UPPER:     cfg_r.upper_limit   <= cfg_pwdata[VAL_W-1:0];
        REG_LOWER:     cfg_r.lower_limit   <= cfg_pwdata[VAL_W-1:0];
        REG_COEF_CUR:  cfg_r.coef_current  <= cfg_pwdata[COEF_W-1:0];
        REG_COEF_PREV: cfg_r.coef_previous <= cfg_pwdata[COEF_W-1:0];
        REG_COEF_OLD:  cfg_r.coef_older    <= cfg_pwdata[COEF_W-1:0];
        REG_MODE:      cfg_r.mode_bits     <= cfg_pwdata[MODE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(cfg_paddr[4:2]))
      REG_SETPOINT:  cfg_prdata = 32'(cfg_r.setpoint);
      REG_DEADBAND:  cfg_prdata = 32'(cfg_r.deadband);
      REG_UPPER:     cfg_prdata = 32'(cfg_r.upper_limit);
      REG_LOWER:     cfg_prdata = 32'(cfg_r.lower_limit);
      REG_COEF_CUR:  cfg_prdata = 32'(cfg_r.coef_current);
      REG_COEF_PREV: cfg_prdata = 32'(cfg_r.coef_previous);
      REG_COEF_OLD:  cfg_prdata = 32'(cfg_r.coef_older);
      REG_MODE:      cfg_prdata = 32'(cfg_r.mode_bits);
      default:       cfg_prdata = '0;
    endcase
  end

  // ---------------- pipeline control ----------------
  // slot 1 drains whenever the result register is free or being taken
  assign s1_move   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_move;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_op_r  <= in_tuser;
      s1_val_r <= in_tdata;
    end
  end

  vpd_datapath u_dp (
    .cfg          (cfg_r),
    .state        (state_r),
    .opcode       (s1_op_r),
    .sample_value (s1_val_r),
    .state_nxt    (state_nxt),
    .updated      (updated)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (s1_move) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_move) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // integer part by arithmetic drop of the fraction bits
  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_data_r <= state_nxt.accum[ACC_W-1:FRAC_BITS];
      out_upd_r  <= updated;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_upd_r;

endmodule

// ===== rtl/vpd_checker.sv =====
// ----------------------------------------------------------------------------
// vpd_checker
// port-level checks of the pid controller, bound to the top level
// ----------------------------------------------------------------------------
`include "velocity_pid_deadband_top_macros.svh"

module vpd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        cfg_pready,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tuser
);

  // a draining result side never backs up the input
  `VPD_ASSERT(a_ready_follows, out_tready |-> in_tready, "input stalled while output drains")

  // a new result beat shows up only after an input beat has passed the input register and the result register
  `VPD_ASSERT(a_out_from_in, $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 2), "result without input beat")

  // reset leaves no result pending
  `VPD_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_tvalid, "result valid after reset")

  `VPD_ASSERT_ALWAYS(a_pready_high, rst_n |-> cfg_pready, "apb pready dropped")

  `VPD_ASSERT(a_out_hold, (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tuser)), "stalled result beat changed")

endmodule

bind velocity_pid_deadband_top vpd_checker u_vpd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .cfg_pready (cfg_pready),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// checks the velocity-form pid controller against a cycle-free predictor:
// directed corner cases, then random register settings and sample streams,
// with bursty input beats and a stalling result side
// ----------------------------------------------------------------------------
module tb;
  import vpd_pkg::*;

  localparam logic [1:0] OP_UNUSED  = 2'd3;
  localparam int         CYCLE_LIMIT = 500000;
  localparam int         RANDOM_ITEMS = 1650;

  typedef struct packed {
    logic [VAL_W-1:0] drive;
    logic             updated;
  } drive_beat_t;

  // predicts drive_output / pid_updated for every accepted beat and holds them in order
  class pid_drive_scoreboard;
    logic signed [VAL_W-1:0]  setpoint;
    logic        [DB_W-1:0]   deadband;
    logic signed [VAL_W-1:0]  upper_lim;
    logic signed [VAL_W-1:0]  lower_lim;
    logic signed [COEF_W-1:0] gain_now;
    logic signed [COEF_W-1:0] gain_prev;
    logic signed [COEF_W-1:0] gain_older;
    logic        [MODE_W-1:0] mode;
    longint      accum;
    longint      err_now;
    longint      err_prev;
    longint      err_older;
    drive_beat_t expected_drive_q[$];
    int          fail_count;

    function new();
      setpoint   = '0;
      deadband   = '0;
      upper_lim  = 16'sd32767;
      lower_lim  = -16'sd32768;
      gain_now   = '0;
      gain_prev  = '0;
      gain_older = '0;
      mode       = '0;
      accum      = 0;
      err_now    = 0;
      err_prev   = 0;
      err_older  = 0;
      fail_count = 0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [31:0] value);
      case (idx)
        REG_SETPOINT:  setpoint   = value[VAL_W-1:0];
        REG_DEADBAND:  deadband   = value[DB_W-1:0];
        REG_UPPER:     upper_lim  = value[VAL_W-1:0];
        REG_LOWER:     lower_lim  = value[VAL_W-1:0];
        REG_COEF_CUR:  gain_now   = value[COEF_W-1:0];
        REG_COEF_PREV: gain_prev  = value[COEF_W-1:0];
        REG_COEF_OLD:  gain_older = value[COEF_W-1:0];
        REG_MODE:      mode       = value[MODE_W-1:0];
        default: ;
      endcase
    endfunction

    // lower bound tested first; with crossed limits a value below lower stays at lower,
    // anything else ends up at upper
    function longint clamp_to_limits(longint v);
      longint lo;
      longint hi;
      lo = longint'(lower_lim) <<< FRAC_BITS;
      hi = longint'(upper_lim) <<< FRAC_BITS;
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    function void note_input(logic [1:0] op, logic signed [VAL_W-1:0] val);
      longint      err;
      longint      mag;
      drive_beat_t beat;
      beat.updated = 1'b0;
      case (op)
        OP_SAMPLE: begin
          if (mode[MODE_AUTO_BIT]) begin
            err = mode[MODE_INV_BIT] ? longint'(val) - longint'(setpoint)
                                     : longint'(setpoint) - longint'(val);
            mag = (err < 0) ? -err : err;
            if (mag >= longint'(deadband)) begin
              err_older = err_prev;
              err_prev  = err_now;
              err_now   = err;
              accum = clamp_to_limits(accum + longint'(gain_now) * err_now
                                            + longint'(gain_prev) * err_prev
                                            + longint'(gain_older) * err_older);
              beat.updated = 1'b1;
            end
          end
        end
        OP_MANUAL: begin
          if (!mode[MODE_AUTO_BIT]) accum = clamp_to_limits(longint'(val) <<< FRAC_BITS);
        end
        OP_CLEAR: begin
          accum     = 0;
          err_now   = 0;
          err_prev  = 0;
          err_older = 0;
        end
        default: ;
      endcase
      // arithmetic shift gives the floor of the fixed-point value
      beat.drive = VAL_W'(accum >>> FRAC_BITS);
      expected_drive_q.push_back(beat);
    endfunction

    function void check_result(logic [VAL_W-1:0] drive, logic updated);
      drive_beat_t want;
      if (expected_drive_q.size() == 0) begin
        $error("unexpected result beat: drive_output %0d", $signed(drive));
        fail_count++;
        return;
      end
      want = expected_drive_q.pop_front();
      if (drive !== want.drive) begin
        $error("drive_output: expected %0d, actual %0d", $signed(want.drive), $signed(drive));
        fail_count++;
      end
      if (updated !== want.updated) begin
        $error("pid_updated: expected %0d, actual %0d", want.updated, updated);
        fail_count++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;   // [15:0] sample_value
  logic [1:0]  in_tuser = '0;   // [1:0] opcode
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;       // [15:0] drive_output
  logic        out_tuser;       // [0] pid_updated

  pid_drive_scoreboard sb = new();

  int          cycle_count = 0;
  int          burst_left = 0;
  bit          steady_run = 1'b0;
  logic [15:0] ready_pattern = 16'hFFFF;
  logic [5:0]  pattern_age = '0;

  velocity_pid_deadband_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // result side: rotating stall pattern, reloaded whenever the 6-bit pattern_age counter wraps
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
    pattern_age <= pattern_age + 1'b1;
    if (pattern_age == '0) begin
      case ($urandom_range(0, 3))
        0:       ready_pattern <= 16'hFFFF;
        1:       ready_pattern <= 16'($urandom);
        2:       ready_pattern <= 16'($urandom & $urandom);
        default: ready_pattern <= 16'($urandom | $urandom);
      endcase
    end else begin
      ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
    end
    out_tready <= steady_run | ready_pattern[0];
  end

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    sb.write_reg(idx, value);
  endtask

  task automatic push_item(input logic [1:0] op, input logic [15:0] val);
    int gap;
    if (burst_left == 0) begin
      gap = steady_run ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= val;
    do @(posedge clk); while (!in_tready);
    sb.note_input(op, val);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (sb.expected_drive_q.size() != 0) @(posedge clk);
  endtask

  function automatic int pick_gain();
    case ($urandom_range(0, 9))
      0:       return 32'sh007F_FFFF;
      1:       return -32'sh0080_0000;
      2:       return int'($signed(24'($urandom)));
      default: return $urandom_range(0, 32'h6_0000) - 32'h3_0000;
    endcase
  endfunction

  task automatic apply_random_setting();
    int a;
    int b;
    case ($urandom_range(0, 9))
      0:       write_reg(REG_SETPOINT, ($urandom_range(0, 1) != 0) ? 32767 : -32768);
      default: write_reg(REG_SETPOINT, 32'($signed(16'($urandom))));
    endcase
    case ($urandom_range(0, 9))
      0:       write_reg(REG_DEADBAND, $urandom_range(0, 32767));
      1:       write_reg(REG_DEADBAND, 32767);
      2, 3:    write_reg(REG_DEADBAND, 0);
      default: write_reg(REG_DEADBAND, $urandom_range(1, 300));
    endcase
    a = int'($signed(16'($urandom)));
    b = int'($signed(16'($urandom)));
    case ($urandom_range(0, 9))
      0: begin
        write_reg(REG_UPPER, 32767);
        write_reg(REG_LOWER, -32768);
      end
      1: begin
        // crossed limits
        write_reg(REG_UPPER, (a < b) ? a : b);
        write_reg(REG_LOWER, (a < b) ? b : a);
      end
      2: begin
        write_reg(REG_UPPER, $urandom_range(0, 400));
        write_reg(REG_LOWER, -$urandom_range(0, 400));
      end
      default: begin
        write_reg(REG_UPPER, (a < b) ? b : a);
        write_reg(REG_LOWER, (a < b) ? a : b);
      end
    endcase
    write_reg(REG_COEF_CUR, pick_gain());
    write_reg(REG_COEF_PREV, pick_gain());
    write_reg(REG_COEF_OLD, pick_gain());
    write_reg(REG_MODE, ($urandom_range(0, 4) == 0) ? $urandom_range(0, 3)
                                                    : (($urandom_range(0, 1) << MODE_INV_BIT)
                                                       | (1 << MODE_AUTO_BIT)));
  endtask

  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
      1:       return ($urandom_range(0, 1) != 0) ? 16'h0000 : 16'hFFFF;
      2, 3, 4: return 16'($urandom);
      // close to the setpoint so the deadband edge gets hit
      default: return 16'(int'(sb.setpoint) + $urandom_range(0, 2 * (sb.deadband + 64))
                          - (sb.deadband + 64));
    endcase
  endfunction

  initial begin
    int          sent;
    int          phase_items;
    int          r;
    logic [1:0]  op;
    logic [15:0] val;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: manual mode, full limits
    push_item(OP_MANUAL, 16'h7FFF);
    push_item(OP_MANUAL, 16'h8000);
    push_item(OP_SAMPLE, 16'd100);
    push_item(OP_UNUSED, 16'h1234);
    push_item(OP_CLEAR, 16'hFFFF);
    push_item(OP_MANUAL, 16'hFFFB);
    wait_drained();

    // widest errors, extreme gains
    write_reg(REG_SETPOINT, 32767);
    write_reg(REG_DEADBAND, 0);
    write_reg(REG_COEF_CUR, 32'sh007F_FFFF);
    write_reg(REG_COEF_PREV, -32'sh0080_0000);
    write_reg(REG_COEF_OLD, -32'sh0080_0000);
    write_reg(REG_MODE, 1 << MODE_AUTO_BIT);
    push_item(OP_SAMPLE, 16'h8000);
    push_item(OP_SAMPLE, 16'h7FFF);
    push_item(OP_MANUAL, 16'd77);
    push_item(OP_SAMPLE, 16'h8000);
    push_item(OP_CLEAR, 16'h0000);
    wait_drained();

    // inverse acting, largest deadband: just inside, on the edge, far out
    write_reg(REG_SETPOINT, -32768);
    write_reg(REG_DEADBAND, 32767);
    write_reg(REG_COEF_CUR, 32'sh0001_0000);
    write_reg(REG_COEF_PREV, 0);
    write_reg(REG_COEF_OLD, 0);
    write_reg(REG_MODE, (1 << MODE_INV_BIT) | (1 << MODE_AUTO_BIT));
    push_item(OP_SAMPLE, 16'hFFFE);
    push_item(OP_SAMPLE, 16'hFFFF);
    push_item(OP_SAMPLE, 16'h7FFF);
    push_item(OP_SAMPLE, 16'h8000);
    wait_drained();

    // crossed limits in manual mode
    write_reg(REG_UPPER, -100);
    write_reg(REG_LOWER, 100);
    write_reg(REG_MODE, 0);
    push_item(OP_MANUAL, 16'h0000);
    push_item(OP_MANUAL, 16'd5000);
    push_item(OP_MANUAL, 16'hEC78);
    wait_drained();

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      apply_random_setting();
      steady_run  = ($urandom_range(0, 4) == 0);
      burst_left  = 0;
      phase_items = $urandom_range(80, 180);
      if (phase_items > RANDOM_ITEMS - sent) phase_items = RANDOM_ITEMS - sent;
      repeat (phase_items) begin
        r = $urandom_range(0, 99);
        if (sb.mode[MODE_AUTO_BIT]) begin
          op = (r < 80) ? OP_SAMPLE : (r < 90) ? OP_MANUAL : (r < 95) ? OP_CLEAR : OP_UNUSED;
        end else begin
          op = (r < 30) ? OP_SAMPLE : (r < 90) ? OP_MANUAL : (r < 95) ? OP_CLEAR : OP_UNUSED;
        end
        val = pick_value();
        push_item(op, val);
      end
      sent += phase_items;
      wait_drained();
    end

    // latency tail
    repeat (8) @(posedge clk);
    if (sb.fail_count == 0 && sb.expected_drive_q.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
